[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

[rtl/dpmst_pkg.sv]
// ----------------------------------------------------------------------------
// dpmst_pkg
// Types and constants shared by the dense Prim tree-weight block.
// ----------------------------------------------------------------------------
package dpmst_pkg;

  localparam int MAX_NODES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int CFG_BITS        = 7;
  localparam int IN_BITS         = 16;
  localparam int TOTAL_BITS      = 22;
  localparam int unsigned TOTAL_MAX = 32'd4194303;

  typedef struct packed {
    logic load_we;
    logic prim_start;
    logic scan_issue;
    logic scan_first;
    logic pick;
  } dpm_cmd_t;

endpackage

[rtl/dpmst_ram.sv]
// ----------------------------------------------------------------------------
// dpmst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/dpmst_ctrl.sv]
// ----------------------------------------------------------------------------
// dpmst_ctrl
// Sequencer: matrix load count, scan index, pick rounds, node count register.
// ----------------------------------------------------------------------------
module dpmst_ctrl import dpmst_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES * MAX_NODES) : 1,
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int NW = $clog2(MAX_NODES + 1),
  localparam int CW = $clog2(MAX_NODES * MAX_NODES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                cfg_valid,
  input  logic [CFG_BITS-1:0] cfg_node_count,
  output logic                cfg_ready,
  output logic                busy,
  output logic                out_valid,
  output dpm_cmd_t            cmd,
  output logic [AW-1:0]       load_addr,
  output logic [IW-1:0]       scan_idx,
  output logic [NW-1:0]       node_cnt
);

  typedef enum logic [1:0] {S_LOAD, S_SCAN, S_DRAIN, S_PICK} state_t;

  state_t        state_r, state_nxt;
  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          first_r, first_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [CW-1:0] cells_r, cells_nxt;
  logic [AW-1:0] load_cnt_r, load_cnt_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [NW-1:0] round_r, round_nxt;
  logic [NW-1:0] n_cfg;
  logic          cfg_we;
  logic          load_last;
  logic          scan_last;
  logic          round_last;

  // a count write never shares an edge with an item
  assign cfg_we     = cfg_valid & ~busy_r & ~start;
  assign load_last  = (CW'(load_cnt_r) + CW'(1)) == cells_r;
  assign scan_last  = (NW'(scan_r) + NW'(1)) == n_r;
  assign round_last = (round_r + NW'(1)) == n_r;

  always_comb begin
    if (cfg_node_count == '0) begin
      n_cfg = NW'(1);
    end else if (int'(cfg_node_count) > MAX_NODES) begin
      n_cfg = NW'(MAX_NODES);
    end else begin
      n_cfg = NW'(cfg_node_count);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    first_nxt     = first_r;
    n_nxt         = n_r;
    cells_nxt     = cells_r;
    load_cnt_nxt  = load_cnt_r;
    scan_nxt      = scan_r;
    round_nxt     = round_r;
    cmd           = '0;
    unique case (state_r)
      S_LOAD: begin
        if (cfg_we) begin
          n_nxt        = n_cfg;
          cells_nxt    = CW'(n_cfg) * CW'(n_cfg);
          load_cnt_nxt = '0;
        end else if (start) begin
          cmd.load_we = 1'b1;
          if (load_last) begin
            cmd.prim_start = 1'b1;
            load_cnt_nxt   = '0;
            scan_nxt       = '0;
            round_nxt      = '0;
            first_nxt      = 1'b1;
            busy_nxt       = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            load_cnt_nxt = load_cnt_r + AW'(1);
          end
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.scan_first = first_r;
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + IW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        first_nxt = 1'b0;
        scan_nxt  = '0;
        if (round_last) begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end else begin
          round_nxt = round_r + NW'(1);
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      n_r         <= NW'(1);
      cells_r     <= CW'(1);
      load_cnt_r  <= '0;
      scan_r      <= '0;
      round_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      n_r         <= n_nxt;
      cells_r     <= cells_nxt;
      load_cnt_r  <= load_cnt_nxt;
      scan_r      <= scan_nxt;
      round_r     <= round_nxt;
    end
  end

  assign cfg_ready = ~busy_r & ~start;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign load_addr = load_cnt_r;
  assign scan_idx  = scan_r;
  assign node_cnt  = n_r;

endmodule

[rtl/dpmst_dp.sv]
// ----------------------------------------------------------------------------
// dpmst_dp
// Datapath: weight and cost memories (each cost entry carries its taken flag),
// relax/min scan pipe, total.
// ----------------------------------------------------------------------------
module dpmst_dp import dpmst_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES * MAX_NODES) : 1,
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int NW = $clog2(MAX_NODES + 1),
  localparam int SW = ((WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS) + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dpm_cmd_t              cmd,
  input  logic [AW-1:0]         load_addr,
  input  logic [IW-1:0]         scan_idx,
  input  logic [NW-1:0]         node_cnt,
  input  logic [IN_BITS-1:0]    in_edge_weight,
  output logic [TOTAL_BITS-1:0] tree_weight
);

  logic [WEIGHT_BITS-1:0] w_rd;
  logic [WEIGHT_BITS:0]   b_rd;
  logic [WEIGHT_BITS-1:0] b_cost;
  logic [WEIGHT_BITS:0]   b_wdata;
  logic [IW-1:0]          b_waddr;
  logic                   b_we;
  logic [WEIGHT_BITS-1:0] best_new;
  logic [AW-1:0]          w_raddr;
  logic                   st_v_r;
  logic [IW-1:0]          st_i_r;
  logic                   st_first_r;
  logic                   min_found_r;
  logic [WEIGHT_BITS-1:0] min_val_r;
  logic [IW-1:0]          min_idx_r;
  logic [TOTAL_BITS-1:0]  total_r, total_nxt;
  logic [AW-1:0]          row_base_r;
  logic [IW+NW-1:0]       row_prod;
  logic [SW-1:0]          sum;
  logic                   tk;
  logic                   relax;
  logic                   cand;

  assign w_raddr = row_base_r + AW'(scan_idx);

  dpmst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_weight_ram (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (load_addr),
    .wdata (WEIGHT_BITS'(in_edge_weight)),
    .raddr (w_raddr),
    .rdata (w_rd)
  );

  // entry = {taken, best cost}; the first round rewrites every flag as clear
  assign b_we    = st_v_r | cmd.pick;
  assign b_waddr = cmd.pick ? min_idx_r : st_i_r;
  assign b_wdata = cmd.pick ? {1'b1, min_val_r} : {tk, best_new};

  dpmst_ram #(.WIDTH(WEIGHT_BITS + 1), .DEPTH(MAX_NODES)) u_best_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (scan_idx),
    .rdata (b_rd)
  );

  assign b_cost   = b_rd[WEIGHT_BITS-1:0];
  assign tk       = ~st_first_r & b_rd[WEIGHT_BITS];
  assign relax    = ~tk & (w_rd < b_cost);
  assign best_new = (st_first_r | relax) ? w_rd : b_cost;
  assign cand     = st_v_r & ~tk & (~min_found_r | (best_new < min_val_r));

  assign sum       = SW'(total_r) + SW'(min_val_r);
  assign total_nxt = (sum > SW'(TOTAL_MAX)) ? TOTAL_BITS'(TOTAL_MAX) : sum[TOTAL_BITS-1:0];
  assign row_prod  = {{NW{1'b0}}, min_idx_r} * {{IW{1'b0}}, node_cnt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r      <= 1'b0;
      min_found_r <= 1'b0;
      total_r     <= '0;
      row_base_r  <= '0;
    end else begin
      st_v_r <= cmd.scan_issue;
      if (cmd.prim_start) begin
        min_found_r <= 1'b0;
        total_r     <= '0;
        row_base_r  <= '0;
      end else if (cmd.pick) begin
        min_found_r <= 1'b0;
        total_r     <= total_nxt;
        row_base_r  <= AW'(row_prod);
      end else if (cand) begin
        min_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_i_r     <= scan_idx;
    st_first_r <= cmd.scan_first;
    if (cand) begin
      min_val_r <= best_new;
      min_idx_r <= st_i_r;
    end
  end

  assign tree_weight = total_r;

endmodule

[rtl/dense_prim_mst_weight.sv]
// ----------------------------------------------------------------------------
// dense_prim_mst_weight
// Minimum spanning tree weight of a dense graph by Prim from node 0.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_node_count sets n (0 reads as 1, above MAX_NODES saturates); a write
//   is taken when cfg_valid and cfg_ready are high and restarts the load.
//   cfg_ready is low while busy or start is high.
//   Edge weights stream in row-major, one item per cycle while busy is low:
//   an item is taken when start is high and busy is low.
//   After the n*n-th item busy rises: each of the n rounds scans the cost
//   memory once, drains the read pipe and picks the least-cost node. The
//   scan of one round reads each entry in turn through the single read port
//   of the weight and cost memories.
//   out_valid is high for one cycle with the total on out_tree_weight, the
//   first cycle with busy low again. The receiver cannot stall; out_valid is
//   not held, though the total stays until the next matrix is loaded.
//   Reset sets n to 1 and clears the load count and total.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dense_prim_mst_weight import dpmst_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_BITS-1:0]    in_edge_weight,
  output logic                  out_valid,
  output logic [TOTAL_BITS-1:0] out_tree_weight,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_BITS-1:0]   cfg_node_count
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES * MAX_NODES) : 1;
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW = $clog2(MAX_NODES + 1);

  dpm_cmd_t      cmd;
  logic [AW-1:0] load_addr;
  logic [IW-1:0] scan_idx;
  logic [NW-1:0] node_cnt;

  dpmst_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .cfg_valid      (cfg_valid),
    .cfg_node_count (cfg_node_count),
    .cfg_ready      (cfg_ready),
    .busy           (busy),
    .out_valid      (out_valid),
    .cmd            (cmd),
    .load_addr      (load_addr),
    .scan_idx       (scan_idx),
    .node_cnt       (node_cnt)
  );

  dpmst_dp #(.MAX_NODES(MAX_NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .load_addr      (load_addr),
    .scan_idx       (scan_idx),
    .node_cnt       (node_cnt),
    .in_edge_weight (in_edge_weight),
    .tree_weight    (out_tree_weight)
  );

  `ASSERT_IMPLY(a_out_after_busy, clk, rst_n, out_valid, $past(busy))
  `ASSERT_NEXT(a_out_single, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMPLY(a_busy_ends_in_result, clk, rst_n, $fell(busy), out_valid)

endmodule
